// ===== src/register_machine_executor_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Register machine executor assertion macros
// Implication checks on the rising edge of i_clk, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef REGISTER_MACHINE_EXECUTOR_UNIT_MACROS_SVH
`define REGISTER_MACHINE_EXECUTOR_UNIT_MACROS_SVH

// Same-cycle implication
`define RME_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define RME_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rme_pkg.sv =====
// ----------------------------------------------------------------------------
// rme_pkg
// Shared types, constants and decode functions of the register machine
// executor.
// ----------------------------------------------------------------------------
package rme_pkg;

    localparam int MEM_BYTES   = 65536;
    localparam int STACK_WORDS = 1024;
    localparam int REG_COUNT   = 256;
    localparam int AW          = $clog2(MEM_BYTES);
    localparam int RW          = $clog2(REG_COUNT);
    localparam int CNT_W       = 6;

    localparam logic [63:0] SP_RESET = 64'(MEM_BYTES - 8);
    localparam logic [63:0] VB_RESET = 64'(MEM_BYTES - 8 - 8 * STACK_WORDS);

    localparam logic [63:0] FLAG_LT  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] FLAG_GT  = 64'h4000_0000_0000_0000;
    localparam logic [63:0] FLAG_EQ  = 64'h2000_0000_0000_0000;
    localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;

    // Error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_OPCODE  = 2'd1;
    localparam logic [1:0] ERR_SYSCALL = 2'd2;

    // Opcodes
    localparam logic [7:0] OP_HALT  = 8'h00;
    localparam logic [7:0] OP_NOP   = 8'hF1;
    localparam logic [7:0] OP_RET   = 8'hF2;
    localparam logic [7:0] OP_CLI   = 8'hF3;
    localparam logic [7:0] OP_STI   = 8'hF4;
    localparam logic [7:0] OP_INT   = 8'h81;
    localparam logic [7:0] OP_GETPC = 8'h82;
    localparam logic [7:0] OP_GETSP = 8'h83;
    localparam logic [7:0] OP_GETVB = 8'h84;
    localparam logic [7:0] OP_GETCR = 8'h85;
    localparam logic [7:0] OP_NOT   = 8'h86;
    localparam logic [7:0] OP_PUSH  = 8'h87;
    localparam logic [7:0] OP_POP   = 8'h88;
    localparam logic [7:0] OP_SETVB = 8'h89;
    localparam logic [7:0] OP_SETSP = 8'h8A;
    localparam logic [7:0] OP_SETCR = 8'h8B;
    localparam logic [7:0] OP_MOV   = 8'h01;
    localparam logic [7:0] OP_LDB   = 8'h02;
    localparam logic [7:0] OP_STB   = 8'h03;
    localparam logic [7:0] OP_ADD   = 8'h04;
    localparam logic [7:0] OP_ADDU  = 8'h05;
    localparam logic [7:0] OP_SUB   = 8'h06;
    localparam logic [7:0] OP_SUBU  = 8'h07;
    localparam logic [7:0] OP_MUL   = 8'h08;
    localparam logic [7:0] OP_MULU  = 8'h09;
    localparam logic [7:0] OP_AND   = 8'h0A;
    localparam logic [7:0] OP_OR    = 8'h0B;
    localparam logic [7:0] OP_XOR   = 8'h0C;
    localparam logic [7:0] OP_BR    = 8'h0D;
    localparam logic [7:0] OP_CALL  = 8'h0E;
    localparam logic [7:0] OP_CMP   = 8'h0F;
    localparam logic [7:0] OP_CMPU  = 8'h10;
    localparam logic [7:0] OP_SHL   = 8'h11;
    localparam logic [7:0] OP_SHR   = 8'h12;
    localparam logic [7:0] OP_DIV   = 8'hC1;
    localparam logic [7:0] OP_DIVU  = 8'hC2;
    localparam logic [7:0] OP_BRL   = 8'hC3;
    localparam logic [7:0] OP_LDI   = 8'hE1;

    // Datapath micro-operations
    localparam logic [4:0] UOP_NONE   = 5'd0;
    localparam logic [4:0] UOP_LOADB  = 5'd1;
    localparam logic [4:0] UOP_HALT   = 5'd2;
    localparam logic [4:0] UOP_ERR1   = 5'd3;
    localparam logic [4:0] UOP_RDREG  = 5'd4;
    localparam logic [4:0] UOP_EXEC   = 5'd5;
    localparam logic [4:0] UOP_WRWORD = 5'd6;
    localparam logic [4:0] UOP_VSETUP = 5'd7;
    localparam logic [4:0] UOP_RDWORD = 5'd8;
    localparam logic [4:0] UOP_POPFIN = 5'd9;
    localparam logic [4:0] UOP_LDBFIN = 5'd10;
    localparam logic [4:0] UOP_MUL    = 5'd11;
    localparam logic [4:0] UOP_MULWB  = 5'd12;
    localparam logic [4:0] UOP_DIV    = 5'd13;
    localparam logic [4:0] UOP_DIVWQ  = 5'd14;
    localparam logic [4:0] UOP_DIVWR  = 5'd15;
    localparam logic [4:0] UOP_OUT    = 5'd16;

    // Step counter end values
    localparam logic [CNT_W-1:0] CNT_WR_LAST  = CNT_W'(7);
    localparam logic [CNT_W-1:0] CNT_RD_LAST  = CNT_W'(8);
    localparam logic [CNT_W-1:0] CNT_MUL_LAST = CNT_W'(3);
    localparam logic [CNT_W-1:0] CNT_DIV_LAST = CNT_W'(63);

    typedef struct packed {
        logic        kind;
        logic [7:0]  opcode;
        logic [7:0]  reg_a;
        logic [7:0]  reg_b;
        logic [7:0]  reg_c;
        logic [63:0] immediate;
        logic [15:0] load_address;
        logic [7:0]  load_byte;
    } t_in;

    typedef struct packed {
        logic [63:0] next_pc;
        logic        halted;
        logic [1:0]  error_code;
        logic        char_valid;
        logic [7:0]  char_value;
    } t_out;

    typedef struct packed {
        logic [4:0] uop;
        logic       take;
    } t_cmd;

    typedef struct packed {
        logic             kind;
        logic [7:0]       opcode;
        logic             ra_one;
        logic             stopped;
        logic             pc_out;
        logic             taken;
        logic             out_free;
        logic [CNT_W-1:0] cnt;
    } t_stat;

    // Instruction length by class
    function automatic logic [3:0] op_len(input logic [7:0] op);
        case (op[7:4])
            4'hF:    op_len = 4'd1;
            4'h8:    op_len = 4'd2;
            4'hC:    op_len = 4'd4;
            4'hE:    op_len = 4'd10;
            default: op_len = 4'd3;
        endcase
    endfunction

    function automatic logic op_known(input logic [7:0] op);
        op_known = op inside {[8'h01:8'h12], [8'h81:8'h8B], [8'hC1:8'hC3],
                              8'hE1, [8'hF1:8'hF4]};
    endfunction

endpackage

// ===== src/rme_ctrl.sv =====
// ----------------------------------------------------------------------------
// rme_ctrl
// Sequencer: decodes the latched item and steps the datapath through
// register read, execute, word memory transfers, multiply and divide.
// ----------------------------------------------------------------------------
module rme_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  rme_pkg::t_stat i_stat,
    output logic           o_stall,
    output rme_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_EXEC  = 4'd2;
    localparam logic [3:0] S_LDB   = 4'd3;
    localparam logic [3:0] S_WRW   = 4'd4;
    localparam logic [3:0] S_VSET  = 4'd5;
    localparam logic [3:0] S_RDW   = 4'd6;
    localparam logic [3:0] S_POPF  = 4'd7;
    localparam logic [3:0] S_MUL   = 4'd8;
    localparam logic [3:0] S_MULWB = 4'd9;
    localparam logic [3:0] S_DIV   = 4'd10;
    localparam logic [3:0] S_DIVQ  = 4'd11;
    localparam logic [3:0] S_DIVR  = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic [7:0] op;

    assign op      = i_stat.opcode;
    assign o_stall = (r_state != S_IDLE);

    // Next state and command
    always_comb begin
        n_state    = r_state;
        o_cmd.uop  = rme_pkg::UOP_NONE;
        o_cmd.take = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_cmd.take = i_valid;
                if (i_valid) n_state = S_DEC;
            end
            S_DEC: begin
                n_state = S_OUT;
                if (i_stat.kind) begin
                    o_cmd.uop = rme_pkg::UOP_LOADB;
                end else if (i_stat.stopped) begin
                    o_cmd.uop = rme_pkg::UOP_NONE;
                end else if (i_stat.pc_out || op == rme_pkg::OP_HALT) begin
                    o_cmd.uop = rme_pkg::UOP_HALT;
                end else if (!rme_pkg::op_known(op)) begin
                    o_cmd.uop = rme_pkg::UOP_ERR1;
                end else begin
                    o_cmd.uop = rme_pkg::UOP_RDREG;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.uop = rme_pkg::UOP_EXEC;
                n_state   = S_OUT;
                case (op)
                    rme_pkg::OP_RET, rme_pkg::OP_POP: n_state = S_RDW;
                    rme_pkg::OP_PUSH:                 n_state = S_WRW;
                    rme_pkg::OP_CALL:  if (i_stat.taken) n_state = S_WRW;
                    rme_pkg::OP_INT:   if (!i_stat.ra_one) n_state = S_WRW;
                    rme_pkg::OP_LDB:                  n_state = S_LDB;
                    rme_pkg::OP_MUL, rme_pkg::OP_MULU: n_state = S_MUL;
                    rme_pkg::OP_DIV, rme_pkg::OP_DIVU: n_state = S_DIV;
                    default: ;
                endcase
            end
            S_LDB: begin
                o_cmd.uop = rme_pkg::UOP_LDBFIN;
                n_state   = S_OUT;
            end
            S_WRW: begin
                o_cmd.uop = rme_pkg::UOP_WRWORD;
                if (i_stat.cnt == rme_pkg::CNT_WR_LAST)
                    n_state = (op == rme_pkg::OP_INT) ? S_VSET : S_OUT;
            end
            S_VSET: begin
                o_cmd.uop = rme_pkg::UOP_VSETUP;
                n_state   = S_RDW;
            end
            S_RDW: begin
                o_cmd.uop = rme_pkg::UOP_RDWORD;
                if (i_stat.cnt == rme_pkg::CNT_RD_LAST) n_state = S_POPF;
            end
            S_POPF: begin
                o_cmd.uop = rme_pkg::UOP_POPFIN;
                n_state   = S_OUT;
            end
            S_MUL: begin
                o_cmd.uop = rme_pkg::UOP_MUL;
                if (i_stat.cnt == rme_pkg::CNT_MUL_LAST) n_state = S_MULWB;
            end
            S_MULWB: begin
                o_cmd.uop = rme_pkg::UOP_MULWB;
                n_state   = S_OUT;
            end
            S_DIV: begin
                o_cmd.uop = rme_pkg::UOP_DIV;
                if (i_stat.cnt == rme_pkg::CNT_DIV_LAST) n_state = S_DIVQ;
            end
            S_DIVQ: begin
                o_cmd.uop = rme_pkg::UOP_DIVWQ;
                n_state   = S_DIVR;
            end
            S_DIVR: begin
                o_cmd.uop = rme_pkg::UOP_DIVWR;
                n_state   = S_OUT;
            end
            S_OUT: begin
                o_cmd.uop = rme_pkg::UOP_OUT;
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/rme_dpath.sv =====
// ----------------------------------------------------------------------------
// rme_dpath
// Datapath: register file, byte memory, architectural registers, shared
// 32x32 multiplier, bit-serial divider and the output register.
// ----------------------------------------------------------------------------
module rme_dpath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rme_pkg::t_cmd  i_cmd,
    input  rme_pkg::t_in   i_item,
    input  logic           i_out_stall,
    output rme_pkg::t_stat o_stat,
    output rme_pkg::t_out  o_out,
    output logic           o_out_valid
);

    localparam int AW    = rme_pkg::AW;
    localparam int RW    = rme_pkg::RW;
    localparam int CNT_W = rme_pkg::CNT_W;

    // Architectural and control state
    logic [63:0]                  r_pc, r_sp, r_vb, r_cr;
    logic                         r_stop, r_cv, r_ov;
    logic [1:0]                   r_err;
    logic [rme_pkg::REG_COUNT-1:0] r_rvld;

    // Payload registers
    rme_pkg::t_in     r_item;
    rme_pkg::t_out    r_out;
    logic [63:0]      r_rda, r_rdb;
    logic             r_vld_a, r_vld_b;
    logic [7:0]       r_cval, r_mq;
    logic [AW-1:0]    r_ma;
    logic [63:0]      r_wd, r_prod, r_acc, r_rem, r_quo, r_dvs;
    logic             r_qneg, r_rneg, r_yz;
    logic [CNT_W-1:0] r_cnt;

    logic [63:0] rf [rme_pkg::REG_COUNT];
    logic [7:0]  mem [rme_pkg::MEM_BYTES];

    logic [7:0]    op;
    logic [RW-1:0] ra, rb, rc, rd_b_addr;
    logic [63:0]   x, y, np, sp_dec, vaddr, cr_cmp, shl, shr, quo_fin, rem_fin;
    logic          taken, lt, gt, sgn, out_free;
    logic          rf_we, mem_we, mem_re;
    logic [RW-1:0] rf_wa;
    logic [63:0]   rf_wd;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wd;
    logic [31:0]   mul_a, mul_b;
    logic [63:0]   mul_p;
    logic [64:0]   rem_sh, dif;

    assign op        = r_item.opcode;
    assign ra        = r_item.reg_a;
    assign rb        = r_item.reg_b;
    assign rc        = r_item.reg_c;
    assign rd_b_addr = (op == rme_pkg::OP_INT) ? RW'(0) : rb;

    // Operands: never-written registers read as zero
    assign x = r_vld_a ? r_rda : 64'd0;
    assign y = r_vld_b ? r_rdb : 64'd0;

    assign np     = r_pc + {60'd0, rme_pkg::op_len(op)};
    assign sp_dec = r_sp - 64'd8;
    assign vaddr  = r_vb + {53'd0, ra, 3'b000};
    assign taken  = ((r_cr & x) == x);

    // Compare flags, signed through the sign-flip trick
    assign sgn    = (op == rme_pkg::OP_CMP);
    assign lt     = sgn ? ((x ^ rme_pkg::SIGN_BIT) < (y ^ rme_pkg::SIGN_BIT)) : (x < y);
    assign gt     = sgn ? ((x ^ rme_pkg::SIGN_BIT) > (y ^ rme_pkg::SIGN_BIT)) : (x > y);
    assign cr_cmp = (r_cr & ~(rme_pkg::FLAG_LT | rme_pkg::FLAG_GT | rme_pkg::FLAG_EQ)) |
                    (lt ? rme_pkg::FLAG_LT : (gt ? rme_pkg::FLAG_GT : rme_pkg::FLAG_EQ));

    assign shl = (|y[63:6]) ? 64'd0 : (x << y[5:0]);
    assign shr = (|y[63:6]) ? 64'd0 : (x >> y[5:0]);

    // Divider step and final sign fix
    assign rem_sh  = {r_rem, r_quo[63]};
    assign dif     = rem_sh - {1'b0, r_dvs};
    assign quo_fin = r_yz ? {64{1'b1}} : (r_qneg ? (64'd0 - r_quo) : r_quo);
    assign rem_fin = r_yz ? x : (r_rneg ? (64'd0 - r_rem) : r_rem);

    assign mul_p    = {32'd0, mul_a} * {32'd0, mul_b};
    assign out_free = !r_ov || !i_out_stall;

    // Write ports, memory port and multiplier operands
    always_comb begin
        rf_we    = 1'b0;
        rf_wa    = ra;
        rf_wd    = 64'd0;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_addr = r_ma;
        mem_wd   = r_wd[63:56];
        mul_a    = x[31:0];
        mul_b    = y[31:0];
        case (i_cmd.uop)
            rme_pkg::UOP_LOADB: begin
                mem_we   = 1'b1;
                mem_addr = AW'(r_item.load_address);
                mem_wd   = r_item.load_byte;
            end
            rme_pkg::UOP_EXEC: begin
                case (op)
                    rme_pkg::OP_GETPC: begin rf_we = 1'b1; rf_wd = np;     end
                    rme_pkg::OP_GETSP: begin rf_we = 1'b1; rf_wd = r_sp;   end
                    rme_pkg::OP_GETVB: begin rf_we = 1'b1; rf_wd = r_vb;   end
                    rme_pkg::OP_GETCR: begin rf_we = 1'b1; rf_wd = r_cr;   end
                    rme_pkg::OP_NOT:   begin rf_we = 1'b1; rf_wd = ~x;     end
                    rme_pkg::OP_MOV:   begin rf_we = 1'b1; rf_wd = y;      end
                    rme_pkg::OP_ADD, rme_pkg::OP_ADDU: begin
                        rf_we = 1'b1; rf_wd = x + y;
                    end
                    rme_pkg::OP_SUB, rme_pkg::OP_SUBU: begin
                        rf_we = 1'b1; rf_wd = x - y;
                    end
                    rme_pkg::OP_AND:   begin rf_we = 1'b1; rf_wd = x & y;  end
                    rme_pkg::OP_OR:    begin rf_we = 1'b1; rf_wd = x | y;  end
                    rme_pkg::OP_XOR:   begin rf_we = 1'b1; rf_wd = x ^ y;  end
                    rme_pkg::OP_SHL:   begin rf_we = 1'b1; rf_wd = shl;    end
                    rme_pkg::OP_SHR:   begin rf_we = 1'b1; rf_wd = shr;    end
                    rme_pkg::OP_LDI:   begin rf_we = 1'b1; rf_wd = r_item.immediate; end
                    rme_pkg::OP_BRL: begin
                        rf_we = taken;
                        rf_wa = rc;
                        rf_wd = np;
                    end
                    rme_pkg::OP_LDB: begin
                        mem_re   = 1'b1;
                        mem_addr = y[AW-1:0];
                    end
                    rme_pkg::OP_STB: begin
                        mem_we   = 1'b1;
                        mem_addr = y[AW-1:0];
                        mem_wd   = x[7:0];
                    end
                    default: ;
                endcase
            end
            rme_pkg::UOP_WRWORD: mem_we = 1'b1;
            rme_pkg::UOP_RDWORD: mem_re = (r_cnt != rme_pkg::CNT_RD_LAST);
            rme_pkg::UOP_LDBFIN: begin
                rf_we = 1'b1;
                rf_wd = {56'd0, r_mq};
            end
            rme_pkg::UOP_POPFIN: begin
                rf_we = (op == rme_pkg::OP_POP);
                rf_wd = r_wd;
            end
            rme_pkg::UOP_MUL: begin
                if (r_cnt == CNT_W'(1)) mul_b = y[63:32];
                if (r_cnt == CNT_W'(2)) mul_a = x[63:32];
            end
            rme_pkg::UOP_MULWB: begin
                rf_we = 1'b1;
                rf_wd = r_acc;
            end
            rme_pkg::UOP_DIVWQ: begin
                rf_we = 1'b1;
                rf_wd = quo_fin;
            end
            rme_pkg::UOP_DIVWR: begin
                rf_we = 1'b1;
                rf_wa = rc;
                rf_wd = rem_fin;
            end
            default: ;
        endcase
    end

    // Register file: one write, two registered reads
    always_ff @(posedge i_clk) begin
        if (rf_we) rf[rf_wa] <= rf_wd;
        if (i_cmd.uop == rme_pkg::UOP_RDREG) begin
            r_rda   <= rf[ra];
            r_rdb   <= rf[rd_b_addr];
            r_vld_a <= r_rvld[ra];
            r_vld_b <= r_rvld[rd_b_addr];
        end
    end

    // Byte memory, single port with registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_addr] <= mem_wd;
        if (mem_re) r_mq <= mem[mem_addr];
    end

    // Architectural state and control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= 64'd0;
            r_sp   <= rme_pkg::SP_RESET;
            r_vb   <= rme_pkg::VB_RESET;
            r_cr   <= 64'd0;
            r_stop <= 1'b0;
            r_err  <= rme_pkg::ERR_NONE;
            r_cv   <= 1'b0;
            r_ov   <= 1'b0;
            r_rvld <= '0;
        end else begin
            if (rf_we) r_rvld[rf_wa] <= 1'b1;
            if (i_cmd.take) begin
                r_err <= rme_pkg::ERR_NONE;
                r_cv  <= 1'b0;
            end
            if (i_cmd.uop == rme_pkg::UOP_OUT && out_free) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            case (i_cmd.uop)
                rme_pkg::UOP_HALT: r_stop <= 1'b1;
                rme_pkg::UOP_ERR1: begin
                    r_stop <= 1'b1;
                    r_err  <= rme_pkg::ERR_OPCODE;
                end
                rme_pkg::UOP_EXEC: begin
                    r_pc <= np;
                    case (op)
                        rme_pkg::OP_INT: begin
                            if (ra == RW'(1)) begin
                                if (y == 64'd1) begin
                                    r_cv <= 1'b1;
                                end else begin
                                    // bad service request: stop at this instruction
                                    r_err  <= rme_pkg::ERR_SYSCALL;
                                    r_stop <= 1'b1;
                                    r_pc   <= r_pc;
                                end
                            end else begin
                                r_sp <= sp_dec;
                            end
                        end
                        rme_pkg::OP_PUSH: r_sp <= sp_dec;
                        rme_pkg::OP_CALL: begin
                            if (taken) begin
                                r_pc <= y;
                                r_sp <= sp_dec;
                            end
                        end
                        rme_pkg::OP_BR, rme_pkg::OP_BRL: if (taken) r_pc <= y;
                        rme_pkg::OP_RET, rme_pkg::OP_POP: r_sp <= r_sp + 64'd8;
                        rme_pkg::OP_SETVB: r_vb <= x;
                        rme_pkg::OP_SETSP: r_sp <= x;
                        rme_pkg::OP_SETCR: r_cr <= x;
                        rme_pkg::OP_CMP, rme_pkg::OP_CMPU: r_cr <= cr_cmp;
                        default: ;
                    endcase
                end
                rme_pkg::UOP_POPFIN: if (op != rme_pkg::OP_POP) r_pc <= r_wd;
                default: ;
            endcase
        end
    end

    // Item, sequencing and arithmetic payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) r_item <= i_item;
        case (i_cmd.uop)
            rme_pkg::UOP_EXEC: begin
                r_cnt <= '0;
                case (op)
                    rme_pkg::OP_RET, rme_pkg::OP_POP: r_ma <= r_sp[AW-1:0];
                    rme_pkg::OP_INT: begin
                        r_cval <= x[7:0];
                        r_ma   <= sp_dec[AW-1:0];
                        r_wd   <= np;
                    end
                    rme_pkg::OP_PUSH: begin
                        r_ma <= sp_dec[AW-1:0];
                        r_wd <= x;
                    end
                    rme_pkg::OP_CALL: begin
                        r_ma <= sp_dec[AW-1:0];
                        r_wd <= np;
                    end
                    rme_pkg::OP_DIV, rme_pkg::OP_DIVU: begin
                        // magnitudes for the signed form, raw for unsigned
                        r_quo  <= ((op == rme_pkg::OP_DIV) && x[63]) ? (64'd0 - x) : x;
                        r_dvs  <= ((op == rme_pkg::OP_DIV) && y[63]) ? (64'd0 - y) : y;
                        r_rem  <= 64'd0;
                        r_qneg <= (op == rme_pkg::OP_DIV) && (x[63] ^ y[63]);
                        r_rneg <= (op == rme_pkg::OP_DIV) && x[63];
                        r_yz   <= (y == 64'd0);
                    end
                    default: ;
                endcase
            end
            rme_pkg::UOP_WRWORD: begin
                r_wd  <= {r_wd[55:0], 8'h00};
                r_ma  <= r_ma + AW'(1);
                r_cnt <= r_cnt + CNT_W'(1);
            end
            rme_pkg::UOP_VSETUP: begin
                r_ma  <= vaddr[AW-1:0];
                r_cnt <= '0;
            end
            rme_pkg::UOP_RDWORD: begin
                if (r_cnt != rme_pkg::CNT_RD_LAST) r_ma <= r_ma + AW'(1);
                if (r_cnt != '0) r_wd <= {r_wd[55:0], r_mq};
                r_cnt <= r_cnt + CNT_W'(1);
            end
            rme_pkg::UOP_MUL: begin
                // low word of x*y from three 32x32 partial products
                r_prod <= mul_p;
                if (r_cnt == CNT_W'(1)) r_acc <= r_prod;
                if (r_cnt == CNT_W'(2) || r_cnt == CNT_W'(3))
                    r_acc <= r_acc + {r_prod[31:0], 32'd0};
                r_cnt <= r_cnt + CNT_W'(1);
            end
            rme_pkg::UOP_DIV: begin
                if (!dif[64]) begin
                    r_rem <= dif[63:0];
                    r_quo <= {r_quo[62:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[63:0];
                    r_quo <= {r_quo[62:0], 1'b0};
                end
                r_cnt <= r_cnt + CNT_W'(1);
            end
            rme_pkg::UOP_OUT: begin
                if (out_free) begin
                    r_out.next_pc    <= r_pc;
                    r_out.halted     <= r_stop;
                    r_out.error_code <= r_err;
                    r_out.char_valid <= r_cv;
                    r_out.char_value <= r_cv ? r_cval : 8'd0;
                end
            end
            default: ;
        endcase
    end

    // Status to the sequencer
    assign o_stat.kind     = r_item.kind;
    assign o_stat.opcode   = op;
    assign o_stat.ra_one   = (ra == RW'(1));
    assign o_stat.stopped  = r_stop;
    assign o_stat.pc_out   = |r_pc[63:AW];
    assign o_stat.taken    = taken;
    assign o_stat.out_free = out_free;
    assign o_stat.cnt      = r_cnt;

    assign o_out       = r_out;
    assign o_out_valid = r_ov;

endmodule

// ===== src/register_machine_executor_unit.sv =====
// Simple instructions pass decode, register read, execute and output; a program byte
// write skips register read and execute. Push/call, pop/return, byte load, vectored
// interrupt, multiply and divide add steps; the byte-serial memory port and the
// bit-serial divider set the long cases. One item at a time: o_stall stays high until
// the result is offered. Reset (synchronous, active low) clears registers, sets SP to
// memory size - 8 and the vector base below the stack.
// ----------------------------------------------------------------------------
// register_machine_executor_unit
// Executes one pre-decoded instruction, or stores one program byte, per item
// of a 64-bit register machine.
// ----------------------------------------------------------------------------
module register_machine_executor_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  rme_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output rme_pkg::t_out o_data
);

    rme_pkg::t_cmd  cmd;
    rme_pkg::t_stat stat;

    // Sequencer
    rme_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_stall (o_stall),
        .o_cmd   (cmd)
    );

    // Datapath
    rme_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_data),
        .i_out_stall (i_stall),
        .o_stat      (stat),
        .o_out       (o_data),
        .o_out_valid (o_valid)
    );

endmodule

// ===== src/rme_chk.sv =====
// ----------------------------------------------------------------------------
// rme_chk
// Port-level checks of the register machine executor, bound to the top level.
// ----------------------------------------------------------------------------
`include "register_machine_executor_unit_macros.svh"

module rme_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_stall,
    input logic          o_valid,
    input logic          i_stall,
    input rme_pkg::t_out o_data
);

    // A held result stays offered
    `RME_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid, "result dropped while stalled")

    // One item at a time: input closes after each transfer
    `RME_ASSERT_NEXT(a_one_item, i_valid && !o_stall, o_stall, "second item taken too early")

    // Any error stops the machine
    `RME_ASSERT_NOW(a_err_halt, o_valid && o_data.error_code != rme_pkg::ERR_NONE,
        o_data.halted, "error without halt")

    // No character byte without the putchar service
    `RME_ASSERT_NOW(a_char_zero, o_valid && !o_data.char_valid,
        o_data.char_value == 8'd0, "stray character byte")

endmodule

bind register_machine_executor_unit rme_chk u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the register machine executor. An in-bench machine
// model tracks registers, stack, vector base, condition word and byte memory
// and predicts every result. A directed opening and a random body follow, and
// the run ends by stopping the machine one of four ways. Memory is preloaded
// before any read so that unwritten bytes are never read.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int    N_RANDOM    = 1250;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam logic [63:0] SAFE_PC = 64'h8000;

    // Machine model: predicts next_pc, stop state, errors and putchar output
    class machine_model;
        logic [7:0]  mem [rme_pkg::MEM_BYTES];
        bit          written [rme_pkg::MEM_BYTES];
        logic [63:0] regs [rme_pkg::REG_COUNT];
        logic [63:0] pc, sp, vb, cr;
        bit          ie, stopped;
        rme_pkg::t_out pending[$];
        int          n_items, n_checked, n_errors, n_chars;

        function new();
            for (int i = 0; i < rme_pkg::MEM_BYTES; i++) begin
                mem[i] = 8'h00;
                written[i] = 1'b0;
            end
            for (int i = 0; i < rme_pkg::REG_COUNT; i++) regs[i] = 64'd0;
            pc = 64'd0;
            sp = rme_pkg::SP_RESET;
            vb = rme_pkg::VB_RESET;
            cr = 64'd0;
            ie = 1'b1;
            stopped = 1'b0;
        endfunction

        function logic [63:0] peek_word(logic [63:0] a);
            logic [63:0] v;
            v = 64'd0;
            for (int i = 0; i < 8; i++) v = {v[55:0], mem[16'(a + 64'(i))]};
            return v;
        endfunction

        function bit word_ready(logic [63:0] a);
            bit ok;
            ok = 1'b1;
            for (int i = 0; i < 8; i++) ok &= written[16'(a + 64'(i))];
            return ok;
        endfunction

        function void poke_byte(logic [63:0] a, logic [7:0] v);
            mem[16'(a)] = v;
            written[16'(a)] = 1'b1;
        endfunction

        function void poke_word(logic [63:0] a, logic [63:0] v);
            for (int i = 0; i < 8; i++) poke_byte(a + 64'(i), v[63-8*i -: 8]);
        endfunction

        function void push(logic [63:0] v);
            sp = sp - 64'd8;
            poke_word(sp, v);
        endfunction

        function logic [63:0] pop();
            logic [63:0] v;
            v = peek_word(sp);
            sp = sp + 64'd8;
            return v;
        endfunction

        function void set_flags(bit lt, bit gt);
            cr &= ~(rme_pkg::FLAG_LT | rme_pkg::FLAG_GT | rme_pkg::FLAG_EQ);
            cr |= lt ? rme_pkg::FLAG_LT : (gt ? rme_pkg::FLAG_GT : rme_pkg::FLAG_EQ);
        endfunction

        function bit taken(logic [63:0] m);
            return (cr & m) == m;
        endfunction

        function bit defined_op(logic [7:0] op);
            case (op)
                rme_pkg::OP_NOP, rme_pkg::OP_RET, rme_pkg::OP_CLI, rme_pkg::OP_STI,
                rme_pkg::OP_INT, rme_pkg::OP_GETPC, rme_pkg::OP_GETSP,
                rme_pkg::OP_GETVB, rme_pkg::OP_GETCR, rme_pkg::OP_NOT,
                rme_pkg::OP_PUSH, rme_pkg::OP_POP, rme_pkg::OP_SETVB,
                rme_pkg::OP_SETSP, rme_pkg::OP_SETCR, rme_pkg::OP_MOV,
                rme_pkg::OP_LDB, rme_pkg::OP_STB, rme_pkg::OP_ADD, rme_pkg::OP_ADDU,
                rme_pkg::OP_SUB, rme_pkg::OP_SUBU, rme_pkg::OP_MUL, rme_pkg::OP_MULU,
                rme_pkg::OP_AND, rme_pkg::OP_OR, rme_pkg::OP_XOR, rme_pkg::OP_BR,
                rme_pkg::OP_CALL, rme_pkg::OP_CMP, rme_pkg::OP_CMPU,
                rme_pkg::OP_SHL, rme_pkg::OP_SHR, rme_pkg::OP_DIV,
                rme_pkg::OP_DIVU, rme_pkg::OP_BRL, rme_pkg::OP_LDI: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        // Apply one accepted item and queue its result
        function void note_item(rme_pkg::t_in d);
            rme_pkg::t_out r;
            logic [63:0] x, y, q, rm, np, cur, ma, mb;
            logic [1:0]  err;
            logic [3:0]  len;
            r = '0;
            err = rme_pkg::ERR_NONE;
            n_items++;
            if (d.kind) begin
                poke_byte(64'(d.load_address), d.load_byte);
            end else if (!stopped) begin
                if (pc >= 64'(rme_pkg::MEM_BYTES) || d.opcode == rme_pkg::OP_HALT) begin
                    stopped = 1'b1;
                end else begin
                    case (d.opcode[7:4])
                        4'hF: len = 4'd1;
                        4'h8: len = 4'd2;
                        4'hC: len = 4'd4;
                        4'hE: len = 4'd10;
                        default: len = 4'd3;
                    endcase
                    cur = pc;
                    np = pc + 64'(len);
                    x = regs[d.reg_a];
                    y = regs[d.reg_b];
                    pc = np;
                    case (d.opcode)
                        rme_pkg::OP_NOP: ;
                        rme_pkg::OP_RET: pc = pop();
                        rme_pkg::OP_CLI: ie = 1'b0;
                        rme_pkg::OP_STI: ie = 1'b1;
                        rme_pkg::OP_INT: begin
                            if (d.reg_a == 8'd1) begin
                                if (regs[0] == 64'd1) begin
                                    r.char_valid = 1'b1;
                                    r.char_value = regs[1][7:0];
                                end else begin
                                    err = rme_pkg::ERR_SYSCALL;
                                end
                            end else begin
                                push(np);
                                pc = peek_word(vb + 64'(d.reg_a) * 64'd8);
                            end
                        end
                        rme_pkg::OP_GETPC: regs[d.reg_a] = np;
                        rme_pkg::OP_GETSP: regs[d.reg_a] = sp;
                        rme_pkg::OP_GETVB: regs[d.reg_a] = vb;
                        rme_pkg::OP_GETCR: regs[d.reg_a] = cr;
                        rme_pkg::OP_NOT:   regs[d.reg_a] = ~x;
                        rme_pkg::OP_PUSH:  push(x);
                        rme_pkg::OP_POP:   regs[d.reg_a] = pop();
                        rme_pkg::OP_SETVB: vb = x;
                        rme_pkg::OP_SETSP: sp = x;
                        rme_pkg::OP_SETCR: cr = x;
                        rme_pkg::OP_MOV:   regs[d.reg_a] = y;
                        rme_pkg::OP_LDB:   regs[d.reg_a] = 64'(mem[16'(y)]);
                        rme_pkg::OP_STB:   poke_byte(y, x[7:0]);
                        rme_pkg::OP_ADD, rme_pkg::OP_ADDU: regs[d.reg_a] = x + y;
                        rme_pkg::OP_SUB, rme_pkg::OP_SUBU: regs[d.reg_a] = x - y;
                        rme_pkg::OP_MUL, rme_pkg::OP_MULU: regs[d.reg_a] = x * y;
                        rme_pkg::OP_AND:   regs[d.reg_a] = x & y;
                        rme_pkg::OP_OR:    regs[d.reg_a] = x | y;
                        rme_pkg::OP_XOR:   regs[d.reg_a] = x ^ y;
                        rme_pkg::OP_BR, rme_pkg::OP_CALL: begin
                            if (taken(x)) begin
                                if (d.opcode == rme_pkg::OP_CALL) push(np);
                                pc = y;
                            end
                        end
                        rme_pkg::OP_CMP:
                            set_flags($signed(x) < $signed(y), $signed(x) > $signed(y));
                        rme_pkg::OP_CMPU: set_flags(x < y, x > y);
                        rme_pkg::OP_SHL: regs[d.reg_a] = (y >= 64) ? 64'd0 : x << y[5:0];
                        rme_pkg::OP_SHR: regs[d.reg_a] = (y >= 64) ? 64'd0 : x >> y[5:0];
                        rme_pkg::OP_DIV: begin
                            if (y == 0) begin
                                q = '1;
                                rm = x;
                            end else begin
                                ma = x[63] ? -x : x;
                                mb = y[63] ? -y : y;
                                q = ma / mb;
                                rm = ma % mb;
                                if (x[63] != y[63]) q = -q;
                                if (x[63]) rm = -rm;
                            end
                            regs[d.reg_a] = q;
                            regs[d.reg_c] = rm;
                        end
                        rme_pkg::OP_DIVU: begin
                            if (y == 0) begin
                                q = '1;
                                rm = x;
                            end else begin
                                q = x / y;
                                rm = x % y;
                            end
                            regs[d.reg_a] = q;
                            regs[d.reg_c] = rm;
                        end
                        rme_pkg::OP_BRL: begin
                            if (taken(x)) begin
                                regs[d.reg_c] = np;
                                pc = y;
                            end
                        end
                        rme_pkg::OP_LDI: regs[d.reg_a] = d.immediate;
                        default: err = rme_pkg::ERR_OPCODE;
                    endcase
                    if (err != rme_pkg::ERR_NONE) begin
                        pc = cur;
                        stopped = 1'b1;
                    end
                end
            end
            r.next_pc = pc;
            r.halted = stopped;
            r.error_code = err;
            if (r.char_valid) n_chars++;
            pending.push_back(r);
        endfunction

        // Compare one result transfer with the oldest prediction
        function void check_result(rme_pkg::t_out got);
            rme_pkg::t_out e;
            if (pending.size() == 0) begin
                $error("result with no prediction pending: %h", got);
                n_errors++;
                return;
            end
            e = pending.pop_front();
            n_checked++;
            if (got.next_pc !== e.next_pc) begin
                $error("next_pc: expected %h, got %h", e.next_pc, got.next_pc);
                n_errors++;
            end
            if (got.halted !== e.halted) begin
                $error("halted: expected %b, got %b", e.halted, got.halted);
                n_errors++;
            end
            if (got.error_code !== e.error_code) begin
                $error("error_code: expected %0d, got %0d", e.error_code, got.error_code);
                n_errors++;
            end
            if (got.char_valid !== e.char_valid) begin
                $error("char_valid: expected %b, got %b", e.char_valid, got.char_valid);
                n_errors++;
            end
            if (got.char_value !== e.char_value) begin
                $error("char_value: expected %h, got %h", e.char_value, got.char_value);
                n_errors++;
            end
        endfunction
    endclass

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_stall;
    rme_pkg::t_in  i_data;
    logic          o_valid;
    logic          i_stall;
    rme_pkg::t_out o_data;

    machine_model mdl;
    int     tx_pct, rx_pct;
    bit     hold_go;
    longint cycles;
    string  stop_how;

    register_machine_executor_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Cycle limit
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Result side: random stall plus one long hold-off
    initial begin
        int hold;
        hold = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_go && hold == 0) begin
                hold = 400;
                hold_go = 1'b0;
            end
            if (hold > 0) begin
                hold--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < rx_pct);
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) mdl.check_result(o_data);
    end

    // Drive one transfer; note it in the model once it is taken
    task automatic send(rme_pkg::t_in it);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= it;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
            @(negedge i_clk);
        end
        mdl.note_item(it);
    endtask

    function automatic rme_pkg::t_in rand_item();
        rme_pkg::t_in t;
        t = '0;
        t.reg_a = 8'($urandom);
        t.reg_b = 8'($urandom);
        t.reg_c = 8'($urandom);
        t.immediate = {$urandom, $urandom};
        t.load_address = 16'($urandom);
        t.load_byte = 8'($urandom);
        t.opcode = rme_pkg::OP_NOP;
        return t;
    endfunction

    function automatic rme_pkg::t_in op3(logic [7:0] op, int a, int b, int c);
        rme_pkg::t_in t;
        t = rand_item();
        t.opcode = op;
        t.reg_a = 8'(a);
        t.reg_b = 8'(b);
        t.reg_c = 8'(c);
        return t;
    endfunction

    function automatic rme_pkg::t_in ldi(int a, logic [63:0] v);
        rme_pkg::t_in t;
        t = op3(rme_pkg::OP_LDI, a, $urandom, $urandom);
        t.immediate = v;
        return t;
    endfunction

    function automatic rme_pkg::t_in byte_load(logic [15:0] a, logic [7:0] v);
        rme_pkg::t_in t;
        t = rand_item();
        t.kind = 1'b1;
        t.opcode = 8'($urandom);
        t.load_address = a;
        t.load_byte = v;
        return t;
    endfunction

    // Fill a word, with a jump target inside the low half of memory when one is needed
    task automatic prep_word(logic [63:0] a, bit need_target);
        logic [63:0] v;
        if (mdl.word_ready(a) && (!need_target || mdl.peek_word(a) < SAFE_PC)) return;
        v = need_target ? 64'($urandom_range(32'h7FFF)) : {$urandom, $urandom};
        for (int i = 0; i < 8; i++) send(byte_load(16'(a + 64'(i)), v[63-8*i -: 8]));
    endtask

    // Issue an instruction after setting up whatever keeps it well defined
    task automatic issue(rme_pkg::t_in c);
        logic [15:0] la;
        if (!c.kind && !mdl.stopped) begin
            if (mdl.pc > 64'hE000) begin
                send(ldi(250, 64'd0));
                send(ldi(251, 64'($urandom_range(16'h3FFF))));
                send(op3(rme_pkg::OP_BR, 250, 251, $urandom));
            end
            case (c.opcode)
                rme_pkg::OP_INT: begin
                    if (c.reg_a == 8'd1) begin
                        if (mdl.regs[0] != 64'd1) send(ldi(0, 64'd1));
                    end else begin
                        prep_word(mdl.vb + 64'(c.reg_a) * 64'd8, 1'b1);
                    end
                end
                rme_pkg::OP_RET: prep_word(mdl.sp, 1'b1);
                rme_pkg::OP_POP: prep_word(mdl.sp, 1'b0);
                rme_pkg::OP_LDB: begin
                    la = 16'(mdl.regs[c.reg_b]);
                    if (!mdl.written[la]) send(byte_load(la, 8'($urandom)));
                end
                rme_pkg::OP_BR, rme_pkg::OP_CALL, rme_pkg::OP_BRL: begin
                    if (mdl.taken(mdl.regs[c.reg_a]) && mdl.regs[c.reg_b] >= SAFE_PC)
                        send(ldi(c.reg_b, 64'($urandom_range(32'h7FFF))));
                end
                default: ;
            endcase
        end
        send(c);
    endtask

    function automatic int pick_reg();
        return ($urandom_range(9) < 7) ? $urandom_range(15) : $urandom_range(255);
    endfunction

    function automatic logic [63:0] pick_imm();
        case ($urandom_range(7))
            0: return 64'($urandom_range(32'h7FFF));
            1: return 64'($urandom_range(70));
            2: return rme_pkg::FLAG_LT >> $urandom_range(2);
            3: return ($urandom_range(1) == 1) ? '1 : 64'd0;
            4: return rme_pkg::SIGN_BIT;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    localparam logic [7:0] OPS [37] = '{
        rme_pkg::OP_NOP, rme_pkg::OP_RET, rme_pkg::OP_CLI, rme_pkg::OP_STI,
        rme_pkg::OP_INT, rme_pkg::OP_GETPC, rme_pkg::OP_GETSP, rme_pkg::OP_GETVB,
        rme_pkg::OP_GETCR, rme_pkg::OP_NOT, rme_pkg::OP_PUSH, rme_pkg::OP_POP,
        rme_pkg::OP_SETVB, rme_pkg::OP_SETSP, rme_pkg::OP_SETCR, rme_pkg::OP_MOV,
        rme_pkg::OP_LDB, rme_pkg::OP_STB, rme_pkg::OP_ADD, rme_pkg::OP_ADDU,
        rme_pkg::OP_SUB, rme_pkg::OP_SUBU, rme_pkg::OP_MUL, rme_pkg::OP_MULU,
        rme_pkg::OP_AND, rme_pkg::OP_OR, rme_pkg::OP_XOR, rme_pkg::OP_BR,
        rme_pkg::OP_CALL, rme_pkg::OP_CMP, rme_pkg::OP_CMPU, rme_pkg::OP_SHL,
        rme_pkg::OP_SHR, rme_pkg::OP_DIV, rme_pkg::OP_DIVU, rme_pkg::OP_BRL,
        rme_pkg::OP_LDI};

    function automatic rme_pkg::t_in rand_instr();
        rme_pkg::t_in t;
        t = op3(OPS[$urandom_range(36)], pick_reg(), pick_reg(), pick_reg());
        if ($urandom_range(3) == 0) t.opcode = rme_pkg::OP_LDI;
        if (t.opcode == rme_pkg::OP_INT && $urandom_range(1) == 1) t.reg_a = 8'd1;
        t.immediate = pick_imm();
        return t;
    endfunction

    // Stimulus
    initial begin
        int how;
        rme_pkg::t_in t;
        mdl = new();
        tx_pct = 23;
        rx_pct = 45;
        hold_go = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, divide corners, shifts, stack, putchar
        send(byte_load(16'hFFFF, 8'hFF));
        send(byte_load(16'h0000, 8'h00));
        issue(ldi(2, '1));
        issue(ldi(3, rme_pkg::SIGN_BIT));
        issue(ldi(4, 64'd0));
        issue(ldi(6, 64'd64));
        issue(op3(rme_pkg::OP_DIV, 7, 3, 5));
        issue(op3(rme_pkg::OP_DIV, 7, 3, 4));
        issue(op3(rme_pkg::OP_DIVU, 8, 2, 8));
        issue(op3(rme_pkg::OP_SHL, 9, 2, 6));
        issue(op3(rme_pkg::OP_SHR, 9, 3, 9));
        issue(op3(rme_pkg::OP_CMP, 3, 2, 0));
        issue(op3(rme_pkg::OP_CMPU, 3, 2, 0));
        issue(op3(rme_pkg::OP_CMP, 2, 2, 0));
        issue(ldi(0, 64'd1));
        issue(ldi(1, 64'h1234_5678_9ABC_DE41));
        issue(op3(rme_pkg::OP_INT, 1, 0, 0));
        issue(op3(rme_pkg::OP_PUSH, 2, 0, 0));
        issue(op3(rme_pkg::OP_POP, 10, 0, 0));
        issue(op3(rme_pkg::OP_LDB, 11, 4, 0));
        issue(op3(rme_pkg::OP_CALL, 4, 6, 0));
        issue(op3(rme_pkg::OP_RET, 0, 0, 0));
        issue(op3(rme_pkg::OP_INT, 255, 0, 0));

        // Random body with the three idling phases
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 3) begin
                tx_pct = 45;
                rx_pct = 23;
            end
            if (i == 2 * N_RANDOM / 3) begin
                tx_pct = 0;
                rx_pct = 0;
                hold_go = 1'b1;
            end
            if ($urandom_range(9) == 0) issue(byte_load(16'($urandom), 8'($urandom)));
            else issue(rand_instr());
        end

        // Stop the machine, then check that it stays stopped
        how = $urandom_range(3);
        case (how)
            0: begin
                stop_how = "halt";
                issue(op3(rme_pkg::OP_HALT, $urandom, $urandom, $urandom));
            end
            1: begin
                stop_how = "unknown opcode";
                t = rand_item();
                do t.opcode = 8'($urandom); while (mdl.defined_op(t.opcode) ||
                                                   t.opcode == rme_pkg::OP_HALT);
                issue(t);
            end
            2: begin
                stop_how = "bad system interrupt";
                send(ldi(0, 64'd2 + 64'($urandom)));
                send(op3(rme_pkg::OP_INT, 1, 0, 0));
            end
            default: begin
                stop_how = "program counter outside memory";
                send(ldi(250, 64'd0));
                send(ldi(251, 64'(rme_pkg::MEM_BYTES) + 64'($urandom_range(1000))));
                send(op3(rme_pkg::OP_BR, 250, 251, 0));
                send(rand_instr());
            end
        endcase
        for (int i = 0; i < 12; i++) begin
            if (i % 3 == 0) send(byte_load(16'($urandom), 8'($urandom)));
            else send(rand_instr());
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        // Drain
        while (mdl.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("Ran %0d items, %0d results checked, %0d characters emitted.",
                 mdl.n_items, mdl.n_checked, mdl.n_chars);
        $display("Machine stopped by %s; %0d mismatches.", stop_how, mdl.n_errors);
        if (mdl.n_errors == 0 && mdl.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
